// ===== rtl/mfvn_pkg.sv =====
`default_nettype none
package mfvn_pkg;

  localparam int MAX_VERTICES_DEF    = 1024;
  localparam int COORD_FRAC_BITS_DEF = 12;
  localparam int IDX_W   = 10;
  localparam int COORD_W = 24;
  localparam int NORM_W  = 16;
  localparam int Q_W     = 15;
  localparam int ROOT_W  = 32;
  localparam int RAD_W   = 64;
  localparam int MAG_W   = 31;

  // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for x < 2^27
  localparam logic [25:0] RECIP3       = 26'd44739243;
  localparam int          RECIP3_SHIFT = 27;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TRI   = 2'd1;
  localparam logic [1:0] MODE_VREAD = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic [IDX_W-1:0]         vertex_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [IDX_W-1:0]         corner_first;
    logic [IDX_W-1:0]         corner_second;
    logic [IDX_W-1:0]         corner_third;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic signed [COORD_W-1:0] anchor_x;
    logic signed [COORD_W-1:0] anchor_y;
    logic signed [COORD_W-1:0] anchor_z;
    logic signed [COORD_W-1:0] tip_x;
    logic signed [COORD_W-1:0] tip_y;
    logic signed [COORD_W-1:0] tip_z;
    logic                      degenerate;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  num;
    logic [ROOT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [25:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 26'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -26'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mfvn_ifs.sv =====
`default_nettype none
interface mfvn_in_if;
  logic                valid;
  logic                ready;
  mfvn_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mfvn_out_if;
  logic                valid;
  logic                ready;
  mfvn_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/mfvn_isqrt.sv =====
`default_nettype none
// one result bit per cycle
module mfvn_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  mfvn_pkg::sqrt_req_t req,
  output mfvn_pkg::sqrt_rsp_t rsp
);

  localparam int RW = mfvn_pkg::ROOT_W;
  localparam int CW = $clog2(RW);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [mfvn_pkg::RAD_W-1:0] rad_r;
  logic [RW+2:0]     rem_r;
  logic [RW-1:0]     root_r;
  logic [RW+2:0]     rem_sh;
  logic [RW+2:0]     trial;
  logic              ge;

  assign rem_sh = {rem_r[RW:0], rad_r[mfvn_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad_r  <= req.radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[mfvn_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule
`default_nettype wire

// ===== rtl/mfvn_div.sv =====
`default_nettype none
// restoring divide, one quotient bit per cycle; requires num <= den
module mfvn_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mfvn_pkg::div_req_t req,
  output mfvn_pkg::div_rsp_t rsp
);

  localparam int QW = mfvn_pkg::Q_W;
  localparam int DW = mfvn_pkg::ROOT_W;
  localparam int CW = $clog2(QW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW+1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] quot_r;
  logic          ge;
  logic [DW+1:0] rem_nxt;

  always_comb begin
    ge      = (rem_r >= {2'b00, den_r});
    rem_nxt = ge ? (rem_r - {2'b00, den_r}) : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= (DW+2)'(req.num);
      den_r  <= req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= {rem_nxt[DW:0], 1'b0};
      quot_r <= {quot_r[QW-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
`default_nettype wire

// ===== rtl/mesh_face_vertex_normals_unit.sv =====
`default_nettype none
// Face and vertex normals of a triangle mesh, one transaction at a time. Vertex
// positions and normal accumulators sit in two single-port-read memories of
// MAX_VERTICES words. A triangle reads its three corners, forms the cross
// product and centroid on one shared 33x33 multiplier, shifts the magnitudes
// below 2^31, sums the squares, runs the 32-step square root and three 15-step
// divides, then read-modify-writes the three accumulators; the divides are
// skipped when the normal is degenerate. The square root and divider dominate.
// The next transaction is taken as soon as the result sits in the output
// register.
module mesh_face_vertex_normals_unit #(
  parameter int MAX_VERTICES    = mfvn_pkg::MAX_VERTICES_DEF,
  parameter int COORD_FRAC_BITS = mfvn_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mfvn_in_if.sink           in_ch,
  mfvn_out_if.source        out_ch
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int HW = mfvn_pkg::Q_W + COORD_FRAC_BITS;
  localparam int CW = mfvn_pkg::COORD_W;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_RDV  = 5'd1;
  localparam logic [4:0] ST_LATV = 5'd2;
  localparam logic [4:0] ST_EDGE = 5'd3;
  localparam logic [4:0] ST_MULS = 5'd4;
  localparam logic [4:0] ST_ABS  = 5'd5;
  localparam logic [4:0] ST_SHF  = 5'd6;
  localparam logic [4:0] ST_SQ   = 5'd7;
  localparam logic [4:0] ST_SQRS = 5'd8;
  localparam logic [4:0] ST_SQRW = 5'd9;
  localparam logic [4:0] ST_DIVS = 5'd10;
  localparam logic [4:0] ST_DIVW = 5'd11;
  localparam logic [4:0] ST_ARD  = 5'd12;
  localparam logic [4:0] ST_AWR  = 5'd13;
  localparam logic [4:0] ST_RD2  = 5'd14;
  localparam logic [4:0] ST_LAT2 = 5'd15;
  localparam logic [4:0] ST_FIN  = 5'd16;

  logic [4:0]                 state_r;
  logic [3:0]                 cnt_r;
  logic                       out_valid_r;
  mfvn_pkg::out_item_t        out_r;

  logic [1:0]                 mode_r;
  logic [mfvn_pkg::IDX_W-1:0] vidx_r;
  logic [mfvn_pkg::IDX_W-1:0] corner_r [3];
  logic signed [CW-1:0]       p_r [3][3];
  logic signed [CW:0]         e1_r [3];
  logic signed [CW:0]         e2_r [3];
  logic signed [CW+1:0]       s_r [3];
  logic signed [51:0]         cr_r [3];
  logic [50:0]                m_r [3];
  logic [2:0]                 neg_r;
  logic [63:0]                sum_r;
  logic [mfvn_pkg::ROOT_W-1:0] len_r;
  logic signed [mfvn_pkg::NORM_W-1:0] nrm_r [3];
  logic signed [CW-1:0]       anc_r [3];
  logic                       deg_r;

  logic signed [32:0]         mul_a;
  logic signed [32:0]         mul_b;
  logic signed [65:0]         mul_p_r;
  logic [CW+1:0]              s_mag [3];
  logic [1:0]                 cix;

  logic [3*CW-1:0]            vtx_mem [MAX_VERTICES];
  logic [3*CW-1:0]            acc_mem [MAX_VERTICES];
  logic [3*CW-1:0]            vrd_r;
  logic [3*CW-1:0]            ard_r;
  logic                       rd_ok_r;
  logic [mfvn_pkg::IDX_W-1:0] rd_idx;
  logic [AW-1:0]              rd_addr;
  logic                       rd_ok;
  logic                       in_acc;
  logic                       v_we;
  logic                       a_we;
  logic [3*CW-1:0]            a_wd;
  logic signed [CW-1:0]       acc_new [3];
  logic signed [CW-1:0]       tip [3];
  logic                       fin_load;

  mfvn_pkg::sqrt_req_t        sqrt_req;
  mfvn_pkg::sqrt_rsp_t        sqrt_rsp;
  mfvn_pkg::div_req_t         div_req;
  mfvn_pkg::div_rsp_t         div_rsp;

  function automatic logic signed [CW-1:0] comp(input logic [3*CW-1:0] w, input int i);
    return w[(2-i)*CW +: CW];
  endfunction

  assign cix      = cnt_r[1:0];
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign fin_load = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // memory addressing
  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_idx = in_ch.payload.vertex_index;
    end else if (state_r == ST_RDV || state_r == ST_ARD || state_r == ST_AWR) begin
      rd_idx = corner_r[cix];
    end else begin
      rd_idx = vidx_r;
    end
    rd_addr = AW'(rd_idx);
    rd_ok   = (32'(rd_idx) < 32'(MAX_VERTICES));
    v_we    = in_acc && (in_ch.payload.mode == mfvn_pkg::MODE_LOAD) && rd_ok;
    a_we    = v_we || ((state_r == ST_AWR) && rd_ok_r);
    for (int i = 0; i < 3; i++) begin
      acc_new[i] = mfvn_pkg::sat24(26'(comp(ard_r, i)) + 26'(nrm_r[i]));
    end
    a_wd = (state_r == ST_IDLE) ? '0 : {acc_new[0], acc_new[1], acc_new[2]};
  end

  always_ff @(posedge clk) begin
    vrd_r   <= vtx_mem[rd_addr];
    ard_r   <= acc_mem[rd_addr];
    rd_ok_r <= rd_ok;
    if (v_we) begin
      vtx_mem[rd_addr] <= {in_ch.payload.pos_x, in_ch.payload.pos_y, in_ch.payload.pos_z};
    end
    if (a_we) begin
      acc_mem[rd_addr] <= a_wd;
    end
  end

  // shared multiplier
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_mag[i] = s_r[i][CW+1] ? (CW+2)'(-s_r[i]) : (CW+2)'(s_r[i]);
    end
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_MULS) begin
      unique case (cnt_r)
        4'd0: begin mul_a = 33'(e1_r[1]); mul_b = 33'(e2_r[2]); end
        4'd1: begin mul_a = 33'(e1_r[2]); mul_b = 33'(e2_r[1]); end
        4'd2: begin mul_a = 33'(e1_r[2]); mul_b = 33'(e2_r[0]); end
        4'd3: begin mul_a = 33'(e1_r[0]); mul_b = 33'(e2_r[2]); end
        4'd4: begin mul_a = 33'(e1_r[0]); mul_b = 33'(e2_r[1]); end
        4'd5: begin mul_a = 33'(e1_r[1]); mul_b = 33'(e2_r[0]); end
        4'd6: begin mul_a = 33'(s_mag[0]); mul_b = 33'(mfvn_pkg::RECIP3); end
        4'd7: begin mul_a = 33'(s_mag[1]); mul_b = 33'(mfvn_pkg::RECIP3); end
        4'd8: begin mul_a = 33'(s_mag[2]); mul_b = 33'(mfvn_pkg::RECIP3); end
        default: ;
      endcase
    end else if (state_r == ST_SQ && cnt_r != 4'd3) begin
      mul_a = 33'(m_r[cix][mfvn_pkg::MAG_W-1:0]);
      mul_b = 33'(m_r[cix][mfvn_pkg::MAG_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // output tip: anchor plus half normal, saturated
  always_comb begin
    logic [mfvn_pkg::NORM_W-1:0] mag;
    logic [HW-1:0]               wide;
    logic signed [CW+1:0]        hs;
    for (int i = 0; i < 3; i++) begin
      mag    = nrm_r[i][mfvn_pkg::NORM_W-1] ? 16'(-nrm_r[i]) : 16'(nrm_r[i]);
      wide   = HW'(mag[mfvn_pkg::Q_W-1:0]) << COORD_FRAC_BITS;
      hs     = (CW+2)'(wide[HW-1:mfvn_pkg::Q_W]);
      hs     = nrm_r[i][mfvn_pkg::NORM_W-1] ? -hs : hs;
      tip[i] = mfvn_pkg::sat24(26'(anc_r[i]) + hs);
    end
  end

  always_comb begin
    sqrt_req.start    = (state_r == ST_SQRS);
    sqrt_req.radicand = sum_r;
    div_req.start     = (state_r == ST_DIVS);
    div_req.num       = m_r[cix][mfvn_pkg::MAG_W-1:0];
    div_req.den       = len_r;
  end

  mfvn_isqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sqrt_req), .rsp(sqrt_rsp));
  mfvn_div   u_div  (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_acc) begin
            if (in_ch.payload.mode == mfvn_pkg::MODE_TRI) begin
              state_r <= ST_RDV;
            end else if (in_ch.payload.mode == mfvn_pkg::MODE_VREAD) begin
              state_r <= ST_RD2;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_RDV:  state_r <= ST_LATV;
        ST_LATV: begin
          if (cnt_r == 4'd2) begin
            cnt_r   <= '0;
            state_r <= ST_EDGE;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= ST_RDV;
          end
        end
        ST_EDGE: state_r <= ST_MULS;
        ST_MULS: begin
          if (cnt_r == 4'd9) begin
            cnt_r   <= '0;
            state_r <= ST_ABS;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_ABS:  state_r <= ST_SHF;
        ST_SHF: begin
          if (m_r[0][50:31] == '0 && m_r[1][50:31] == '0 && m_r[2][50:31] == '0) begin
            cnt_r   <= '0;
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (cnt_r == 4'd3) begin
            cnt_r   <= '0;
            state_r <= ST_SQRS;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_SQRS: state_r <= ST_SQRW;
        ST_SQRW: begin
          cnt_r <= '0;
          if (sqrt_rsp.done) begin
            if (sqrt_rsp.root != '0) begin
              state_r <= ST_DIVS;
            end else begin
              state_r <= (mode_r == mfvn_pkg::MODE_TRI) ? ST_ARD : ST_FIN;
            end
          end
        end
        ST_DIVS: state_r <= ST_DIVW;
        ST_DIVW: begin
          if (div_rsp.done) begin
            if (cnt_r == 4'd2) begin
              cnt_r   <= '0;
              state_r <= (mode_r == mfvn_pkg::MODE_TRI) ? ST_ARD : ST_FIN;
            end else begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= ST_DIVS;
            end
          end
        end
        ST_ARD:  state_r <= ST_AWR;
        ST_AWR: begin
          if (cnt_r == 4'd2) begin
            cnt_r   <= '0;
            state_r <= ST_FIN;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= ST_ARD;
          end
        end
        ST_RD2:  state_r <= ST_LAT2;
        ST_LAT2: state_r <= ST_ABS;
        ST_FIN: begin
          if (fin_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    logic [3:0]  k;
    logic [24:0] q3;
    k  = cnt_r - 4'd1;
    q3 = mul_p_r[mfvn_pkg::RECIP3_SHIFT +: 25];
    if (in_acc) begin
      mode_r      <= in_ch.payload.mode;
      vidx_r      <= in_ch.payload.vertex_index;
      corner_r[0] <= in_ch.payload.corner_first;
      corner_r[1] <= in_ch.payload.corner_second;
      corner_r[2] <= in_ch.payload.corner_third;
      deg_r       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        nrm_r[i] <= '0;
        anc_r[i] <= '0;
      end
    end
    if (state_r == ST_LATV) begin
      for (int i = 0; i < 3; i++) begin
        p_r[cix][i] <= rd_ok_r ? comp(vrd_r, i) : '0;
      end
    end
    if (state_r == ST_LAT2) begin
      for (int i = 0; i < 3; i++) begin
        anc_r[i] <= rd_ok_r ? comp(vrd_r, i) : '0;
        cr_r[i]  <= rd_ok_r ? 52'(comp(ard_r, i)) : '0;
      end
    end
    if (state_r == ST_EDGE) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= 25'(p_r[1][i]) - 25'(p_r[0][i]);
        e2_r[i] <= 25'(p_r[2][i]) - 25'(p_r[0][i]);
        s_r[i]  <= 26'(p_r[0][i]) + 26'(p_r[1][i]) + 26'(p_r[2][i]);
      end
    end
    if (state_r == ST_MULS && cnt_r != 4'd0) begin
      unique case (k)
        4'd0: cr_r[0] <= 52'(mul_p_r);
        4'd1: cr_r[0] <= cr_r[0] - 52'(mul_p_r);
        4'd2: cr_r[1] <= 52'(mul_p_r);
        4'd3: cr_r[1] <= cr_r[1] - 52'(mul_p_r);
        4'd4: cr_r[2] <= 52'(mul_p_r);
        4'd5: cr_r[2] <= cr_r[2] - 52'(mul_p_r);
        4'd6: anc_r[0] <= s_r[0][CW+1] ? 24'(-q3) : 24'(q3);
        4'd7: anc_r[1] <= s_r[1][CW+1] ? 24'(-q3) : 24'(q3);
        4'd8: anc_r[2] <= s_r[2][CW+1] ? 24'(-q3) : 24'(q3);
        default: ;
      endcase
    end
    if (state_r == ST_ABS) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= cr_r[i][51];
        m_r[i]   <= cr_r[i][51] ? 51'(-cr_r[i]) : 51'(cr_r[i]);
      end
    end
    if (state_r == ST_SHF) begin
      if (!(m_r[0][50:31] == '0 && m_r[1][50:31] == '0 && m_r[2][50:31] == '0)) begin
        for (int i = 0; i < 3; i++) begin
          m_r[i] <= m_r[i] >> 1;
        end
      end
      sum_r <= '0;
    end
    if (state_r == ST_SQ && cnt_r != 4'd0) begin
      sum_r <= sum_r + mul_p_r[63:0];
    end
    if (state_r == ST_SQRW && sqrt_rsp.done) begin
      len_r <= sqrt_rsp.root;
      if (sqrt_rsp.root == '0) begin
        deg_r <= 1'b1;
      end
    end
    if (state_r == ST_DIVW && div_rsp.done) begin
      nrm_r[cix] <= neg_r[cix] ? -16'(div_rsp.quot) : 16'(div_rsp.quot);
    end
    if (fin_load) begin
      out_r.normal_x   <= nrm_r[0];
      out_r.normal_y   <= nrm_r[1];
      out_r.normal_z   <= nrm_r[2];
      out_r.anchor_x   <= anc_r[0];
      out_r.anchor_y   <= anc_r[1];
      out_r.anchor_z   <= anc_r[2];
      out_r.tip_x      <= tip[0];
      out_r.tip_y      <= tip[1];
      out_r.tip_z      <= tip[2];
      out_r.degenerate <= deg_r;
    end
  end

`ifndef SYNTH
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (len_r != '0))
    else $error("divide finished with zero length");

  a_sq_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ) |->
      (m_r[0][50:31] == '0 && m_r[1][50:31] == '0 && m_r[2][50:31] == '0))
    else $error("squares started before magnitudes fit");

  a_sqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_rsp.done |-> (state_r == ST_SQRW))
    else $error("square root finished outside its wait state");

  a_unit_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |->
      (nrm_r[0] <= 16'sd16384 && nrm_r[0] >= -16'sd16384 &&
       nrm_r[1] <= 16'sd16384 && nrm_r[1] >= -16'sd16384 &&
       nrm_r[2] <= 16'sd16384 && nrm_r[2] >= -16'sd16384))
    else $error("normal component beyond unit range");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_mesh_face_vertex_normals_unit.sv =====
`default_nettype none
module tb_mesh_face_vertex_normals_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int NVERT = 1024;
  localparam longint S24_HI = 64'sd8388607;
  localparam longint S24_LO = -64'sd8388608;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_FROM = 3000;
  localparam int HOLD_LEN = 500;

  typedef longint vec3_t[3];
  typedef struct {
    mfvn_pkg::in_item_t item;
    bit                 drain;
  } pend_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  mfvn_in_if  in_ch();
  mfvn_out_if out_ch();

  mesh_face_vertex_normals_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  pend_t               pend_q[$];
  mfvn_pkg::out_item_t normals_due[$];
  int                  errors = 0;

  longint pos_mem[NVERT][3];
  longint acc_mem[NVERT][3];

  function automatic longint clamp24(longint v);
    if (v > S24_HI) return S24_HI;
    if (v < S24_LO) return S24_LO;
    return v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_normal(input vec3_t c, output vec3_t n);
    longint unsigned m[3], mx, sum, len;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_root(sum);
    for (int i = 0; i < 3; i++) n[i] = 0;
    if (len == 0) return 1'b1;
    for (int i = 0; i < 3; i++) begin
      n[i] = longint'((m[i] << 14) / len);
      if (c[i] < 0) n[i] = -n[i];
    end
    return 1'b0;
  endfunction

  function automatic longint half_len(longint n);
    longint unsigned m;
    longint h;
    m = n < 0 ? -n : n;
    h = longint'((m << 12) >> 15);
    return n < 0 ? -h : h;
  endfunction

  function automatic mfvn_pkg::out_item_t pack_result(vec3_t n, vec3_t a, bit deg);
    mfvn_pkg::out_item_t r;
    r.normal_x = 16'(n[0]);
    r.normal_y = 16'(n[1]);
    r.normal_z = 16'(n[2]);
    r.anchor_x = 24'(a[0]);
    r.anchor_y = 24'(a[1]);
    r.anchor_z = 24'(a[2]);
    r.tip_x = 24'(clamp24(a[0] + half_len(n[0])));
    r.tip_y = 24'(clamp24(a[1] + half_len(n[1])));
    r.tip_z = 24'(clamp24(a[2] + half_len(n[2])));
    r.degenerate = deg;
    return r;
  endfunction

  function automatic mfvn_pkg::out_item_t predict_normals(mfvn_pkg::in_item_t it);
    mfvn_pkg::out_item_t r;
    vec3_t p0, p1, p2, e1, e2, cr, n, a;
    int c0, c1, c2, vi;
    bit deg;
    r = '0;
    vi = int'(it.vertex_index);
    case (it.mode)
      mfvn_pkg::MODE_LOAD: begin
        pos_mem[vi][0] = longint'(it.pos_x);
        pos_mem[vi][1] = longint'(it.pos_y);
        pos_mem[vi][2] = longint'(it.pos_z);
        for (int i = 0; i < 3; i++) acc_mem[vi][i] = 0;
      end
      mfvn_pkg::MODE_TRI: begin
        c0 = int'(it.corner_first);
        c1 = int'(it.corner_second);
        c2 = int'(it.corner_third);
        for (int i = 0; i < 3; i++) begin
          p0[i] = pos_mem[c0][i];
          p1[i] = pos_mem[c1][i];
          p2[i] = pos_mem[c2][i];
          e1[i] = p1[i] - p0[i];
          e2[i] = p2[i] - p0[i];
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        deg = unit_normal(cr, n);
        for (int i = 0; i < 3; i++) begin
          acc_mem[c0][i] = clamp24(acc_mem[c0][i] + n[i]);
          acc_mem[c1][i] = clamp24(acc_mem[c1][i] + n[i]);
          acc_mem[c2][i] = clamp24(acc_mem[c2][i] + n[i]);
          a[i] = (p0[i] + p1[i] + p2[i]) / 3;
        end
        r = pack_result(n, a, deg);
      end
      mfvn_pkg::MODE_VREAD: begin
        for (int i = 0; i < 3; i++) begin
          cr[i] = acc_mem[vi][i];
          a[i] = pos_mem[vi][i];
        end
        deg = unit_normal(cr, n);
        r = pack_result(n, a, deg);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // stimulus generation; tracks which slots hold a vertex
  bit gen_written[NVERT];
  int written_list[$];
  bit next_drain = 1'b0;

  function automatic mfvn_pkg::in_item_t noise_item();
    mfvn_pkg::in_item_t it;
    it.mode = MODE_NONE;
    it.vertex_index = 10'($urandom);
    it.pos_x = 24'($urandom);
    it.pos_y = 24'($urandom);
    it.pos_z = 24'($urandom);
    it.corner_first = 10'($urandom);
    it.corner_second = 10'($urandom);
    it.corner_third = 10'($urandom);
    return it;
  endfunction

  task automatic push_item(mfvn_pkg::in_item_t it);
    pend_t p;
    p.item = it;
    p.drain = next_drain;
    next_drain = 1'b0;
    pend_q = {pend_q, p};
  endtask

  task automatic add_load(int idx, int x, int y, int z);
    mfvn_pkg::in_item_t it;
    it = noise_item();
    it.mode = mfvn_pkg::MODE_LOAD;
    it.vertex_index = 10'(idx);
    it.pos_x = 24'(x);
    it.pos_y = 24'(y);
    it.pos_z = 24'(z);
    if (!gen_written[idx]) begin
      gen_written[idx] = 1'b1;
      written_list = {written_list, idx};
    end
    push_item(it);
  endtask

  task automatic add_tri(int a, int b, int c);
    mfvn_pkg::in_item_t it;
    it = noise_item();
    it.mode = mfvn_pkg::MODE_TRI;
    it.corner_first = 10'(a);
    it.corner_second = 10'(b);
    it.corner_third = 10'(c);
    push_item(it);
  endtask

  task automatic add_read(int idx);
    mfvn_pkg::in_item_t it;
    it = noise_item();
    it.mode = mfvn_pkg::MODE_VREAD;
    it.vertex_index = 10'(idx);
    push_item(it);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 8388607 : -8388608;
      1: return int'($urandom_range(0, 16777215)) - 8388608;
      2: return int'($urandom_range(0, 8191)) - 4096;
      default: return int'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic int pick_vertex();
    int n;
    n = written_list.size();
    if ($urandom_range(0, 1) && n > 8) return written_list[n - 1 - $urandom_range(0, 7)];
    return written_list[$urandom_range(0, n - 1)];
  endfunction

  // sender: bursts and gaps; a drain-marked transaction waits for all results
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin : sender
    pend_t p;
    bit take;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left <= $urandom_range(1, 20);
      gap_left <= 0;
    end else begin
      take = in_ch.valid && in_ch.ready;
      if (take) normals_due = {normals_due, predict_normals(in_ch.payload)};
      if (in_ch.valid && !take) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pend_q.size() == 0 || (pend_q[0].drain && normals_due.size() != 0)) begin
        in_ch.valid <= 1'b0;
      end else begin
        p = pend_q.pop_front();
        in_ch.payload <= p.item;
        in_ch.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 160)
                                                  : $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: rotating stall pattern of three kinds, plus one long hold-off
  int rcv_cyc = 0;
  always @(posedge clk) begin : receiver
    int kind;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rcv_cyc <= rcv_cyc + 1;
      kind = (rcv_cyc / 64) % 3;
      if (rcv_cyc >= HOLD_FROM && rcv_cyc < HOLD_FROM + HOLD_LEN)
        out_ch.ready <= 1'b0;
      else if (kind == 0)
        out_ch.ready <= 1'b1;
      else if (kind == 1)
        out_ch.ready <= 1'($urandom_range(0, 1));
      else
        out_ch.ready <= ($urandom_range(0, 4) != 0);
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    mfvn_pkg::out_item_t e, g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g = out_ch.payload;
      if (normals_due.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = normals_due.pop_front();
        check_field("normal_x", e.normal_x, g.normal_x);
        check_field("normal_y", e.normal_y, g.normal_y);
        check_field("normal_z", e.normal_z, g.normal_z);
        check_field("anchor_x", e.anchor_x, g.anchor_x);
        check_field("anchor_y", e.anchor_y, g.anchor_y);
        check_field("anchor_z", e.anchor_z, g.anchor_z);
        check_field("tip_x", e.tip_x, g.tip_x);
        check_field("tip_y", e.tip_y, g.tip_y);
        check_field("tip_z", e.tip_z, g.tip_z);
        check_field("degenerate", e.degenerate, g.degenerate);
      end
    end
  end

  int watchdog = 0;
  always @(posedge clk) begin
    watchdog <= watchdog + 1;
    if (watchdog >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int sel;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NVERT; i++)
      for (int j = 0; j < 3; j++) begin
        pos_mem[i][j] = 0;
        acc_mem[i][j] = 0;
      end

    // directed: extremes, degenerate and repeated corners, reload clears
    add_load(0, 8388607, 8388607, 8388607);
    add_load(1, -8388608, 8388607, -8388608);
    add_load(2, 8388607, -8388608, 0);
    add_load(1023, 0, 0, 0);
    add_load(4, 4096, 0, 0);
    add_load(5, 0, 4096, 0);
    add_load(6, 0, 0, 4096);
    add_tri(0, 1, 2);
    add_tri(4, 5, 6);
    add_tri(6, 5, 4);
    add_tri(4, 4, 5);
    add_tri(1023, 1023, 1023);
    add_read(4);
    add_read(1023);
    add_read(0);
    push_item(noise_item());
    add_load(4, -4096, -1, 1);
    add_read(4);
    add_tri(2, 1, 1023);
    add_read(2);

    next_drain = 1'b1;
    for (int k = 0; k < 1530; k++) begin
      if (k % 300 == 150) next_drain = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 22 || written_list.size() < 12)
        add_load($urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
      else if (sel < 70)
        add_tri(pick_vertex(), pick_vertex(), pick_vertex());
      else if (sel < 95)
        add_read(pick_vertex());
      else
        push_item(noise_item());
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_ch.valid || normals_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire

// ===== mesh_face_vertex_normals_unit.f =====
rtl/mfvn_pkg.sv
rtl/mfvn_ifs.sv
rtl/mfvn_isqrt.sv
rtl/mfvn_div.sv
rtl/mesh_face_vertex_normals_unit.sv
bench/tb_mesh_face_vertex_normals_unit.sv
